// ===== rtl/core/rrlc_pkg.sv =====
// Shared types and codes for the cached rectangular region lookup.
package rrlc_pkg;

    localparam int LINK_BITS = 6;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_AREA  = 2'd1;
    localparam logic [1:0] ACT_ADJ   = 2'd2;

    localparam logic [3:0] FLD_LAYER = 4'd0;
    localparam logic [3:0] FLD_XS    = 4'd1;
    localparam logic [3:0] FLD_YS    = 4'd2;
    localparam logic [3:0] FLD_XE    = 4'd3;
    localparam logic [3:0] FLD_YE    = 4'd4;
    localparam logic [3:0] FLD_BANK  = 4'd5;
    localparam logic [3:0] FLD_LINK0 = 4'd6;

    localparam logic CFG_ACTIVE_LAYER = 1'b0;
    localparam logic CFG_REGION_COUNT = 1'b1;

    typedef struct packed {
        logic [1:0]  action;
        logic [5:0]  entry_index;
        logic [3:0]  field_select;
        logic [15:0] field_value;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
    } t_cmd;

    typedef struct packed {
        logic       found;
        logic [5:0] region_index;
        logic [7:0] region_bank;
    } t_result;

endpackage

// ===== rtl/core/rrlc_table.sv =====
// Region table memories with one field write port and one registered read port.
module rrlc_table #(
    parameter int MAX_REGIONS = 64,
    parameter int COORD_BITS  = 16,
    parameter int NEIGHBOURS  = 4,
    parameter int IDX_W       = 6
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [IDX_W-1:0]      i_waddr,
    input  logic [3:0]            i_wsel,
    input  logic [15:0]           i_wdata,
    input  logic [IDX_W-1:0]      i_raddr,
    output logic [7:0]            o_layer,
    output logic [COORD_BITS-1:0] o_xs,
    output logic [COORD_BITS-1:0] o_ys,
    output logic [COORD_BITS-1:0] o_xe,
    output logic [COORD_BITS-1:0] o_ye,
    output logic [7:0]            o_bank,
    output logic [NEIGHBOURS-1:0][rrlc_pkg::LINK_BITS-1:0] o_links
);

    localparam int NB_W = (NEIGHBOURS > 1) ? $clog2(NEIGHBOURS) : 1;

    logic [7:0]            mem_layer [MAX_REGIONS];
    logic [COORD_BITS-1:0] mem_xs    [MAX_REGIONS];
    logic [COORD_BITS-1:0] mem_ys    [MAX_REGIONS];
    logic [COORD_BITS-1:0] mem_xe    [MAX_REGIONS];
    logic [COORD_BITS-1:0] mem_ye    [MAX_REGIONS];
    logic [7:0]            mem_bank  [MAX_REGIONS];
    logic [NEIGHBOURS-1:0][rrlc_pkg::LINK_BITS-1:0] mem_links [MAX_REGIONS];

    logic [3:0] link_slot;

    assign link_slot = i_wsel - rrlc_pkg::FLD_LINK0;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            unique case (i_wsel)
                rrlc_pkg::FLD_LAYER: mem_layer[i_waddr] <= i_wdata[7:0];
                rrlc_pkg::FLD_XS:    mem_xs[i_waddr]    <= COORD_BITS'(i_wdata);
                rrlc_pkg::FLD_YS:    mem_ys[i_waddr]    <= COORD_BITS'(i_wdata);
                rrlc_pkg::FLD_XE:    mem_xe[i_waddr]    <= COORD_BITS'(i_wdata);
                rrlc_pkg::FLD_YE:    mem_ye[i_waddr]    <= COORD_BITS'(i_wdata);
                rrlc_pkg::FLD_BANK:  mem_bank[i_waddr]  <= i_wdata[7:0];
                default: begin
                    if (i_wsel >= rrlc_pkg::FLD_LINK0 && 32'(link_slot) < NEIGHBOURS) begin
                        mem_links[i_waddr][NB_W'(link_slot)] <=
                            i_wdata[rrlc_pkg::LINK_BITS-1:0];
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        o_layer <= mem_layer[i_raddr];
        o_xs    <= mem_xs[i_raddr];
        o_ys    <= mem_ys[i_raddr];
        o_xe    <= mem_xe[i_raddr];
        o_ye    <= mem_ye[i_raddr];
        o_bank  <= mem_bank[i_raddr];
        o_links <= mem_links[i_raddr];
    end

endmodule

// ===== rtl/core/rrlc_match.sv =====
// Shared compare unit that tests one region record against the layer and position.
module rrlc_match #(
    parameter int COORD_BITS = 16
) (
    input  logic [7:0]            i_layer,
    input  logic [COORD_BITS-1:0] i_xs,
    input  logic [COORD_BITS-1:0] i_ys,
    input  logic [COORD_BITS-1:0] i_xe,
    input  logic [COORD_BITS-1:0] i_ye,
    input  logic [7:0]            i_active_layer,
    input  logic [15:0]           i_pos_x,
    input  logic [15:0]           i_pos_y,
    output logic                  o_hit
);

    logic [31:0] px;
    logic [31:0] py;

    assign px = 32'(i_pos_x);
    assign py = 32'(i_pos_y);

    assign o_hit = (i_layer == i_active_layer) &&
                   (px >= 32'(i_xs)) && (py >= 32'(i_ys)) &&
                   (px <= 32'(i_xe)) && (py <= 32'(i_ye));

endmodule

// ===== rtl/core/rect_region_lookup_cached_unit.sv =====
// Top level of the cached rectangular region lookup with its sequencer.
//
// A command word is taken on i_cmd at a clock edge where start is high and
// busy is low. Action write sets one field of one table entry; area lookup
// searches for the region holding (pos_x, pos_y) on the active layer;
// adjacent lookup tests the current region and then its neighbor links.
// Every command gives one result word on o_result, shown for exactly one
// cycle with o_done high. The receiver cannot stall the block.
// A write or unused action, or an adjacent lookup with no current region, gives
// its result in the cycle after acceptance and leaves busy low. An area lookup
// that hits the cached region answers from the cached-region test state;
// otherwise one compare unit walks the table, reading an entry while testing the previous
// one behind a registered memory read, over region_count entries (at most MAX_REGIONS).
// An adjacent lookup tests at most NEIGHBOURS links. Configuration registers are
// written through i_cfg_we, i_cfg_idx and i_cfg_data; the user must do so only while the
// block is idle, which the block does not enforce. Synchronous reset clears the cached and
// current regions and configuration registers; table contents are undefined until written.
module rect_region_lookup_cached_unit #(
    parameter int MAX_REGIONS = 64,
    parameter int COORD_BITS  = 16,
    parameter int NEIGHBOURS  = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  rrlc_pkg::t_cmd    i_cmd,
    output logic              o_done,
    output rrlc_pkg::t_result o_result,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [7:0]        i_cfg_data
);

    localparam int IDX_W  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int NB_W   = (NEIGHBOURS > 1) ? $clog2(NEIGHBOURS) : 1;
    localparam int CNT_W  = $clog2(((MAX_REGIONS > NEIGHBOURS) ? MAX_REGIONS : NEIGHBOURS) + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CTEST = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [7:0]       r_active_layer;
    logic [6:0]       r_region_count;
    logic [IDX_W-1:0] r_cached_idx, n_cached_idx;
    logic             r_cached_valid, n_cached_valid;
    logic [IDX_W-1:0] r_current_idx, n_current_idx;
    logic             r_current_valid, n_current_valid;
    logic             r_area, n_area;
    logic [CNT_W-1:0] r_addr, n_addr;
    logic             r_pv, n_pv;
    logic [IDX_W-1:0] r_pidx, n_pidx;
    logic [15:0]      r_pos_x, n_pos_x;
    logic [15:0]      r_pos_y, n_pos_y;
    logic [NEIGHBOURS-1:0][rrlc_pkg::LINK_BITS-1:0] r_links, n_links;
    logic             r_done, n_done;
    rrlc_pkg::t_result r_result, n_result;

    logic             accept;
    logic             wr_en;
    logic [IDX_W-1:0] rd_addr;
    logic [CNT_W-1:0] scan_n;
    logic [CNT_W-1:0] scan_lim;
    logic             issue_ok;
    logic             cand_ok;
    logic [rrlc_pkg::LINK_BITS-1:0] cur_link;
    logic             hit;

    logic [7:0]            t_layer;
    logic [COORD_BITS-1:0] t_xs;
    logic [COORD_BITS-1:0] t_ys;
    logic [COORD_BITS-1:0] t_xe;
    logic [COORD_BITS-1:0] t_ye;
    logic [7:0]            t_bank;
    logic [NEIGHBOURS-1:0][rrlc_pkg::LINK_BITS-1:0] t_links;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign wr_en    = accept && (i_cmd.action == rrlc_pkg::ACT_WRITE) &&
                      (32'(i_cmd.entry_index) < MAX_REGIONS);
    assign scan_n   = (32'(r_region_count) < MAX_REGIONS) ? CNT_W'(r_region_count)
                                                           : CNT_W'(MAX_REGIONS);
    assign scan_lim = r_area ? scan_n : CNT_W'(NEIGHBOURS);
    assign issue_ok = (r_addr < scan_lim);
    assign cur_link = r_links[r_addr[NB_W-1:0]];
    assign cand_ok  = r_area || (32'(cur_link) < MAX_REGIONS);
    assign o_done   = r_done;
    assign o_result = r_result;

    always_comb begin
        if (r_state == S_SCAN) begin
            rd_addr = r_area ? r_addr[IDX_W-1:0] : IDX_W'(cur_link);
        end else if (r_state == S_IDLE && i_cmd.action == rrlc_pkg::ACT_AREA) begin
            rd_addr = r_cached_idx;
        end else begin
            rd_addr = r_current_idx;
        end
    end

    rrlc_table #(
        .MAX_REGIONS (MAX_REGIONS),
        .COORD_BITS  (COORD_BITS),
        .NEIGHBOURS  (NEIGHBOURS),
        .IDX_W       (IDX_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (IDX_W'(i_cmd.entry_index)),
        .i_wsel  (i_cmd.field_select),
        .i_wdata (i_cmd.field_value),
        .i_raddr (rd_addr),
        .o_layer (t_layer),
        .o_xs    (t_xs),
        .o_ys    (t_ys),
        .o_xe    (t_xe),
        .o_ye    (t_ye),
        .o_bank  (t_bank),
        .o_links (t_links)
    );

    rrlc_match #(
        .COORD_BITS (COORD_BITS)
    ) u_match (
        .i_layer        (t_layer),
        .i_xs           (t_xs),
        .i_ys           (t_ys),
        .i_xe           (t_xe),
        .i_ye           (t_ye),
        .i_active_layer (r_active_layer),
        .i_pos_x        (r_pos_x),
        .i_pos_y        (r_pos_y),
        .o_hit          (hit)
    );

    always_comb begin
        n_state         = r_state;
        n_cached_idx    = r_cached_idx;
        n_cached_valid  = r_cached_valid;
        n_current_idx   = r_current_idx;
        n_current_valid = r_current_valid;
        n_area          = r_area;
        n_addr          = r_addr;
        n_pv            = r_pv;
        n_pidx          = r_pidx;
        n_pos_x         = r_pos_x;
        n_pos_y         = r_pos_y;
        n_links         = r_links;
        n_done          = 1'b0;
        n_result        = r_result;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_pos_x = i_cmd.pos_x;
                    n_pos_y = i_cmd.pos_y;
                    n_pidx  = rd_addr;
                    n_addr  = '0;
                    n_pv    = 1'b0;
                    if (i_cmd.action == rrlc_pkg::ACT_AREA) begin
                        n_area  = 1'b1;
                        n_state = r_cached_valid ? S_CTEST : S_SCAN;
                    end else if (i_cmd.action == rrlc_pkg::ACT_ADJ && r_current_valid) begin
                        n_area  = 1'b0;
                        n_state = S_CTEST;
                    end else begin
                        n_done   = 1'b1;
                        n_result = '0;
                    end
                end
            end
            S_CTEST: begin
                if (hit) begin
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                    n_result = '{found: 1'b1, region_index: 6'(r_pidx), region_bank: t_bank};
                    n_current_idx = r_pidx;
                end else begin
                    n_state = S_SCAN;
                    n_links = t_links;
                end
            end
            S_SCAN: begin
                if (r_pv && hit) begin
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                    n_result = '{found: 1'b1, region_index: 6'(r_pidx), region_bank: t_bank};
                    n_current_idx = r_pidx;
                    if (r_area) begin
                        n_cached_idx    = r_pidx;
                        n_cached_valid  = 1'b1;
                        n_current_valid = 1'b1;
                    end
                end else if (!issue_ok && !r_pv) begin
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                    n_result = '0;
                    if (r_area) begin
                        n_cached_valid = 1'b0;
                    end
                end else begin
                    n_pv   = issue_ok && cand_ok;
                    n_pidx = rd_addr;
                    if (issue_ok) begin
                        n_addr = r_addr + CNT_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_active_layer  <= '0;
            r_region_count  <= '0;
            r_cached_idx    <= '0;
            r_cached_valid  <= 1'b0;
            r_current_idx   <= '0;
            r_current_valid <= 1'b0;
            r_done          <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_cached_idx    <= n_cached_idx;
            r_cached_valid  <= n_cached_valid;
            r_current_idx   <= n_current_idx;
            r_current_valid <= n_current_valid;
            r_done          <= n_done;
            if (i_cfg_we && i_cfg_idx == rrlc_pkg::CFG_ACTIVE_LAYER) begin
                r_active_layer <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == rrlc_pkg::CFG_REGION_COUNT) begin
                r_region_count <= i_cfg_data[6:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_area   <= n_area;
        r_addr   <= n_addr;
        r_pv     <= n_pv;
        r_pidx   <= n_pidx;
        r_pos_x  <= n_pos_x;
        r_pos_y  <= n_pos_y;
        r_links  <= n_links;
        r_result <= n_result;
    end

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("Result shown while the sequencer is still busy.");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_result.found |-> o_result.region_index == 6'd0 &&
                                     o_result.region_bank == 8'd0)
        else $error("A miss carries a nonzero index or bank.");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_addr <= scan_lim)
        else $error("Scan address ran past its limit.");

    a_area_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_cmd.action == rrlc_pkg::ACT_AREA |=> busy && !o_done)
        else $error("Area lookup did not enter the search.");

    a_cache_current: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_cached_valid) |-> r_current_valid && r_current_idx == r_cached_idx)
        else $error("A new cached region is not also the current region.");

endmodule
